@@ rtl/core/modular_exponentiation_assert.svh @@
// Assertion macros used by the modular exponentiation top level.
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define MX_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("modexp: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define MX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("modexp: next-cycle check failed");

`endif

@@ rtl/core/modexp_pkg.sv @@
// Shared types and constants of the modular exponentiation block.
`default_nettype none

package modexp_pkg;

  // Fixed width of the item fields and of the modulus register
  localparam int FIELD_W = 32;

  // Modulus after reset
  localparam logic [FIELD_W-1:0] MODULUS_RESET = 32'd23;

  // Status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/modexp_reduce.sv @@
// Bit-serial restoring reduction: x mod m, one bit of x per cycle.
`default_nettype none

module modexp_reduce #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [OPERAND_WIDTH-1:0]  x_in,
  input  logic [OPERAND_WIDTH-1:0]  m_in,
  output modexp_pkg::unit_stat_t    stat,
  output logic [OPERAND_WIDTH-1:0]  remainder
);

  localparam int CW = $clog2(OPERAND_WIDTH + 1);

  logic [OPERAND_WIDTH-1:0] x_r;
  logic [OPERAND_WIDTH-1:0] m_r;
  logic [OPERAND_WIDTH-1:0] rem_r;
  logic [CW-1:0]            cnt_r;
  logic                     active_r;
  logic                     done_r;
  logic [OPERAND_WIDTH:0]   trial;
  logic [OPERAND_WIDTH:0]   rem_nxt;

  // Shift the next dividend bit in and subtract the modulus if it fits
  always_comb begin
    trial = {rem_r, x_r[OPERAND_WIDTH-1]};
    if (trial >= {1'b0, m_r}) begin
      rem_nxt = trial - {1'b0, m_r};
    end else begin
      rem_nxt = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        x_r      <= x_in;
        m_r      <= m_in;
        rem_r    <= '0;
        cnt_r    <= CW'(OPERAND_WIDTH);
        active_r <= 1'b1;
      end else if (active_r) begin
        rem_r <= rem_nxt[OPERAND_WIDTH-1:0];
        x_r   <= x_r << 1;
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = active_r;
  assign stat.done = done_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

@@ rtl/core/modexp_mulmod.sv @@
// Bit-serial shift-add modular multiplier: a * b mod m, one bit of b per cycle.
`default_nettype none

module modexp_mulmod #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [OPERAND_WIDTH-1:0]  a_in,
  input  logic [OPERAND_WIDTH-1:0]  b_in,
  input  logic [OPERAND_WIDTH-1:0]  m_in,
  output modexp_pkg::unit_stat_t    stat,
  output logic [OPERAND_WIDTH-1:0]  product
);

  localparam int CW = $clog2(OPERAND_WIDTH + 1);

  logic [OPERAND_WIDTH-1:0] a_r;
  logic [OPERAND_WIDTH-1:0] b_r;
  logic [OPERAND_WIDTH-1:0] m_r;
  logic [OPERAND_WIDTH-1:0] acc_r;
  logic [CW-1:0]            cnt_r;
  logic                     active_r;
  logic                     done_r;

  // (x + y) mod m for x, y below m
  function automatic logic [OPERAND_WIDTH-1:0] add_mod(
    input logic [OPERAND_WIDTH-1:0] x,
    input logic [OPERAND_WIDTH-1:0] y,
    input logic [OPERAND_WIDTH-1:0] m
  );
    logic [OPERAND_WIDTH:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[OPERAND_WIDTH-1:0];
  endfunction

  // LSB of b selects an add; a doubles every step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r      <= a_in;
        b_r      <= b_in;
        m_r      <= m_in;
        acc_r    <= '0;
        cnt_r    <= CW'(OPERAND_WIDTH);
        active_r <= 1'b1;
      end else if (active_r) begin
        if (b_r[0]) begin
          acc_r <= add_mod(acc_r, a_r, m_r);
        end
        a_r   <= add_mod(a_r, a_r, m_r);
        b_r   <= b_r >> 1;
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = active_r;
  assign stat.done = done_r;
  assign product   = acc_r;

endmodule

`default_nettype wire

@@ rtl/core/modular_exponentiation.sv @@
// Top level: right-to-left square-and-multiply modular exponentiation.
//
// An item is taken when start is high and busy is low; one result per item is
// shown on the out_ ports for a single cycle with out_valid, and the receiver
// cannot stall it. A zero modulus or a zero exponent gives the result on the
// cycle after acceptance (zero modulus: result 0 with the error flag; zero
// exponent: result 1), and busy stays low. Otherwise the base is first reduced,
// then each exponent bit up to the highest set one passes through a decision
// state, one modular multiply when the bit is set and one squaring when higher
// bits remain, every multiply on a single shared bit-serial multiplier. Busy is
// low again when the result strobe is shown, so the next item can be taken in
// that cycle. The modulus is sampled when the item is accepted; cfg_ready is
// always high.
`default_nettype none

`include "modular_exponentiation_assert.svh"

module modular_exponentiation #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Command channel
  input  logic                              start,
  output logic                              busy,
  input  logic [modexp_pkg::FIELD_W-1:0]    in_base_value,
  input  logic [modexp_pkg::FIELD_W-1:0]    in_exponent,
  // Result strobe
  output logic                              out_valid,
  output logic [modexp_pkg::FIELD_W-1:0]    out_power_result,
  output logic                              out_zero_modulus_error,
  // Modulus register write
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [modexp_pkg::FIELD_W-1:0]    cfg_modulus
);

  localparam int W = OPERAND_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_BIT,
    S_MUL,
    S_SQR
  } state_t;

  state_t                           state_r;
  logic [modexp_pkg::FIELD_W-1:0]   modulus_r;
  logic [W-1:0]                     m_r;
  logic [W-1:0]                     e_r;
  logic [W-1:0]                     b_r;
  logic [W-1:0]                     r_r;
  logic                             red_start_r;
  logic                             mul_start_r;
  logic [W-1:0]                     mul_a_r;
  logic [W-1:0]                     mul_b_r;
  logic                             out_valid_r;
  logic [modexp_pkg::FIELD_W-1:0]   out_power_result_r;
  logic                             out_err_r;

  logic [W-1:0]                     m_in;
  logic [W-1:0]                     base_in;
  logic [W-1:0]                     exp_in;
  logic                             accept;
  modexp_pkg::unit_stat_t           red_stat;
  modexp_pkg::unit_stat_t           mul_stat;
  logic [W-1:0]                     red_rem;
  logic [W-1:0]                     mul_prod;

  // Operands masked to the datapath width
  assign m_in    = W'(modulus_r);
  assign base_in = W'(in_base_value);
  assign exp_in  = W'(in_exponent);
  assign accept  = start && (state_r == S_IDLE);

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= modexp_pkg::MODULUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      modulus_r <= cfg_modulus;
    end
  end

  modexp_reduce #(
    .OPERAND_WIDTH(W)
  ) u_reduce (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (red_start_r),
    .x_in      (b_r),
    .m_in      (m_r),
    .stat      (red_stat),
    .remainder (red_rem)
  );

  modexp_mulmod #(
    .OPERAND_WIDTH(W)
  ) u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start_r),
    .a_in    (mul_a_r),
    .b_in    (mul_b_r),
    .m_in    (m_r),
    .stat    (mul_stat),
    .product (mul_prod)
  );

  // Sequencer: reduce base, then multiply and square per exponent bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      red_start_r <= 1'b0;
      mul_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      red_start_r <= 1'b0;
      mul_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            m_r <= m_in;
            b_r <= base_in;
            e_r <= exp_in;
            r_r <= W'(1);
            if (m_in == '0) begin
              out_valid_r        <= 1'b1;
              out_power_result_r <= '0;
              out_err_r          <= 1'b1;
            end else if (exp_in == '0) begin
              out_valid_r        <= 1'b1;
              out_power_result_r <= modexp_pkg::FIELD_W'(1);
              out_err_r          <= 1'b0;
            end else begin
              red_start_r <= 1'b1;
              state_r     <= S_RED;
            end
          end
        end
        S_RED: begin
          if (red_stat.done) begin
            b_r     <= red_rem;
            state_r <= S_BIT;
          end
        end
        S_BIT: begin
          if (e_r[0]) begin
            mul_a_r     <= r_r;
            mul_b_r     <= b_r;
            mul_start_r <= 1'b1;
            state_r     <= S_MUL;
          end else if (e_r == '0) begin
            out_valid_r        <= 1'b1;
            out_power_result_r <= modexp_pkg::FIELD_W'(r_r);
            out_err_r          <= 1'b0;
            state_r            <= S_IDLE;
          end else begin
            mul_a_r     <= b_r;
            mul_b_r     <= b_r;
            mul_start_r <= 1'b1;
            state_r     <= S_SQR;
          end
        end
        S_MUL: begin
          if (mul_stat.done) begin
            r_r <= mul_prod;
            // no higher set bits: the result is final
            if ((e_r >> 1) == '0) begin
              out_valid_r        <= 1'b1;
              out_power_result_r <= modexp_pkg::FIELD_W'(mul_prod);
              out_err_r          <= 1'b0;
              state_r            <= S_IDLE;
            end else begin
              mul_a_r     <= b_r;
              mul_b_r     <= b_r;
              mul_start_r <= 1'b1;
              state_r     <= S_SQR;
            end
          end
        end
        S_SQR: begin
          if (mul_stat.done) begin
            b_r     <= mul_prod;
            e_r     <= e_r >> 1;
            state_r <= S_BIT;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy                   = (state_r != S_IDLE);
  assign cfg_ready              = 1'b1;
  assign out_valid              = out_valid_r;
  assign out_power_result       = out_power_result_r;
  assign out_zero_modulus_error = out_err_r;

  // Checks
  `MX_ASSERT_IMPLY(a_err_zero_result, clk, rst_n,
    out_valid_r && out_err_r, out_power_result_r == '0)
  `MX_ASSERT_IMPLY(a_mul_start_idle, clk, rst_n,
    mul_start_r, !mul_stat.busy && !red_stat.busy)
  `MX_ASSERT_NEXT(a_work_goes_busy, clk, rst_n,
    accept && (m_in != '0) && (exp_in != '0), busy && !out_valid_r)

endmodule

`default_nettype wire

@@ sim/modular_exponentiation_tb.sv @@
// Self-checking testbench for the square-and-multiply modular exponentiation block.
`default_nettype none

module modular_exponentiation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS  = 10;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int TAIL_CYCLES  = 2400;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 35;

  typedef logic [modexp_pkg::FIELD_W-1:0] word_t;

  // One expected result, with the item that caused it kept for reporting
  typedef struct {
    word_t base;
    word_t exponent;
    word_t power;
    logic  zero_mod;
  } power_item_t;

  // Predicts base^exponent mod modulus and checks results in order
  class power_scoreboard;
    word_t       modulus;
    power_item_t expected_powers[$];
    int          mismatches;

    function new();
      modulus    = modexp_pkg::MODULUS_RESET;
      mismatches = 0;
    endfunction

    // Exact products at double width, so plain remainder is enough
    function power_item_t predict_power(word_t base, word_t exponent);
      power_item_t r;
      bit [63:0]   m;
      bit [63:0]   acc;
      bit [63:0]   sq;
      word_t       e;
      r.base     = base;
      r.exponent = exponent;
      r.zero_mod = (modulus == '0);
      r.power    = '0;
      if (!r.zero_mod) begin
        m   = {32'd0, modulus};
        acc = 64'd1;
        sq  = {32'd0, base} % m;
        e   = exponent;
        while (e != '0) begin
          if (e[0]) acc = (acc * sq) % m;
          e  = e >> 1;
          sq = (sq * sq) % m;
        end
        // zero exponent leaves the unreduced 1
        r.power = acc[modexp_pkg::FIELD_W-1:0];
      end
      return r;
    endfunction

    function void note_item(word_t base, word_t exponent);
      expected_powers.push_back(predict_power(base, exponent));
    endfunction

    function void check_result(word_t power, logic zero_mod);
      power_item_t want;
      if (expected_powers.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: power %h zero_mod %b", power, zero_mod);
        return;
      end
      want = expected_powers.pop_front();
      if (power !== want.power || zero_mod !== want.zero_mod) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch base %h exp %h: power exp %h got %h, zero_mod exp %b got %b",
                   want.base, want.exponent, want.power, power, want.zero_mod, zero_mod);
      end
    endfunction

    function int pending();
      return expected_powers.size();
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  word_t in_base_value = '0;
  word_t in_exponent = '0;
  logic  out_valid;
  word_t out_power_result;
  logic  out_zero_modulus_error;
  logic  cfg_valid = 1'b0;
  logic  cfg_ready;
  word_t cfg_modulus = '0;

  power_scoreboard powers = new();
  int    cycles = 0;
  bit    steady = 1'b0;

  modular_exponentiation u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_base_value          (in_base_value),
    .in_exponent            (in_exponent),
    .out_valid              (out_valid),
    .out_power_result       (out_power_result),
    .out_zero_modulus_error (out_zero_modulus_error),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_modulus            (cfg_modulus)
  );

  always #6 clk = ~clk;

  // Result strobe cannot be held off: check every one
  always @(posedge clk) begin
    if (rst_n && out_valid) powers.check_result(out_power_result, out_zero_modulus_error);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Present one item, possibly after an idle gap; start stays high afterwards
  task automatic send_item(word_t base, word_t exponent);
    if (!steady && $urandom_range(0, 99) < 34) begin
      start <= 1'b0;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 60)) @(posedge clk);
      else repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start         <= 1'b1;
    in_base_value <= base;
    in_exponent   <= exponent;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    powers.note_item(base, exponent);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain();
    start <= 1'b0;
    while (powers.pending() != 0) @(posedge clk);
  endtask

  task automatic write_modulus(word_t value);
    cfg_valid   <= 1'b1;
    cfg_modulus <= value;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    powers.modulus = value;
    cfg_valid <= 1'b0;
  endtask

  function automatic word_t pick_modulus();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 32'd1;
      2:       return '1;
      3:       return word_t'($urandom_range(2, 1000));
      4:       return word_t'(1) << $urandom_range(1, 31);
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic word_t pick_base(word_t modulus);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return modulus - 32'd1;
      2:       return 32'd1;
      3:       return '1;
      default: return word_t'($urandom);
    endcase
  endfunction

  // Mostly full-width exponents, with short and edge values mixed in
  function automatic word_t pick_exponent();
    case ($urandom_range(0, 19))
      0, 1:          return '0;
      2:             return 32'd1;
      3:             return '1;
      4, 5, 6, 7, 8: return word_t'($urandom_range(2, 255));
      default:       return word_t'($urandom);
    endcase
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset modulus of 23: zero base, zero exponent, all-ones operands and small cases
    send_item(32'd0, 32'd0);
    send_item(32'd5, 32'd0);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(32'd2, 32'd11);
    send_item(32'd22, 32'd1);
    drain();

    // Zero modulus flags an error, whatever the exponent
    write_modulus(32'd0);
    send_item(32'd7, 32'd0);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(32'd3, 32'd5);
    drain();

    // Modulus of one: 1 for zero exponent, 0 otherwise
    write_modulus(32'd1);
    send_item(32'd9, 32'd0);
    send_item(32'd9, 32'd3);
    send_item(32'd0, 32'd1);
    drain();

    // Largest modulus
    write_modulus(32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF, 32'd7);
    send_item(32'h1234_5678, 32'h8000_0000);
    send_item(32'd2, 32'd32);
    drain();

    // Largest 32-bit prime
    write_modulus(32'hFFFF_FFFB);
    send_item(32'hFFFF_FFFA, 32'd2);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFA);
    drain();

    // Smallest modulus with real reduction
    write_modulus(32'd2);
    send_item(32'd3, 32'hFFFF_FFFF);
    send_item(32'd4, 32'd1);
    drain();

    // Random phases, one modulus each; one phase sends without random idle gaps
    for (int p = 0; p < RAND_PHASES; p++) begin
      word_t modulus;
      modulus = pick_modulus();
      write_modulus(modulus);
      steady = (p == 4);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_item(pick_base(modulus), pick_exponent());
        // occasional hold-off until the block has emptied
        if ((p == 2 && i == PHASE_ITEMS / 2) || $urandom_range(0, 99) < 3) drain();
      end
      drain();
    end
    steady = 1'b0;

    // Catch any stray strobe
    repeat (TAIL_CYCLES) @(posedge clk);
    if (powers.mismatches == 0 && powers.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
